// ===== design/b2r_pkg.sv =====
// Shared constants and types for the BMP pixel to RGB555 writer.
`default_nettype none

package b2r_pkg;

    // Field and register widths.
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned DIM_W    = 10;
    localparam int unsigned STRIDE_W = 11;
    localparam int unsigned ADDR_W   = 16;
    localparam int unsigned PIX_W    = 16;
    localparam int unsigned CFG_IDX_W = 3;

    // Register file indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_DEPTH_MODE   = 3'd2,
        CFG_DEST_X       = 3'd3,
        CFG_DEST_Y       = 3'd4,
        CFG_DEST_STRIDE  = 3'd5
    } cfg_index_t;

    // Source pixel formats.
    typedef enum logic [1:0] {
        DEPTH_NONE = 2'd0,
        DEPTH_16   = 2'd1,
        DEPTH_24   = 2'd2,
        DEPTH_32   = 2'd3
    } depth_t;

    // Reset value of the destination stride.
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 11'd256;

    // Marker bit set on every frame-buffer word.
    localparam logic [PIX_W-1:0] PIX_OPAQUE = 16'h8000;

endpackage : b2r_pkg

`default_nettype wire

// ===== design/bmp_pixel_to_rgb555_writer_unit.sv =====
// Top level of the BMP pixel to RGB555 frame-buffer writer.
//
// The s_ channel carries the pixel-data bytes of a bottom-up BMP, one byte
// per transaction, header excluded. The m_ channel carries one frame-buffer
// write per complete source pixel: the buffer word address, the RGB555 word
// with bit 15 set, and tlast on the final pixel of the image. Padding bytes
// and bytes inside a pixel produce no transaction.
// The cfg_ port writes the image size, source depth and destination placement;
// the user must write it only while the block is idle; the block does not enforce this.
// A byte is captured in an input register and then converted, together with
// the pixel and row counters, into the output register, which drives m_tvalid.
// One byte is accepted per clock while the receiver does not stall, limited
// by the single counter update per byte.
// When the receiver stalls, the output register holds its write and the
// input register holds one more byte before s_tready falls.
// A synchronous active-low reset clears both channels, the counters and
// the configuration registers (stride returns to 256 words).
`default_nettype none

module bmp_pixel_to_rgb555_writer_unit
    import b2r_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Configuration write port.
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [STRIDE_W-1:0]   cfg_wdata,
    // Byte input channel.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [BYTE_W-1:0]     s_tdata,   // [7:0] data_byte
    // Frame-buffer write channel.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [ADDR_W+PIX_W-1:0]    m_tdata,   // [15:0] write_address, [31:16] pixel_value
    output logic                       m_tlast    // last_pixel
);

    // Configuration registers.
    logic [DIM_W-1:0]    image_width_reg;
    logic [DIM_W-1:0]    image_height_reg;
    logic [1:0]          depth_mode_reg;
    logic [DIM_W-1:0]    dest_x_reg;
    logic [DIM_W-1:0]    dest_y_reg;
    logic [STRIDE_W-1:0] dest_stride_reg;

    // Input stage.
    logic              in_vld_reg, in_vld_next;
    logic [BYTE_W-1:0] in_byte_reg;

    // Conversion state.
    logic [1:0]       byte_phase_reg, byte_phase_next;
    logic [PIX_W-1:0] partial_reg, partial_next;
    logic [DIM_W-1:0] column_reg, column_next;
    logic [DIM_W-1:0] row_reg, row_next;
    logic [1:0]       row_phase_reg, row_phase_next;
    logic             in_padding_reg, in_padding_next;

    // Output stage.
    logic              out_vld_reg, out_vld_next;
    logic [ADDR_W-1:0] out_addr_reg, out_addr_next;
    logic [PIX_W-1:0]  out_pix_reg, out_pix_next;
    logic              out_last_reg, out_last_next;

    // Handshake and datapath terms.
    logic                  advance;
    logic                  process;
    logic                  enabled;
    logic                  emit;
    logic [2:0]            pixel_bytes;
    logic                  pixel_done;
    logic [4:0]            top5;
    logic [DIM_W-1:0]      flipped;
    logic [DIM_W:0]        dest_row;
    logic [2*STRIDE_W-1:0] row_offset;
    logic                  column_end;
    logic                  row_end;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= '0;
            image_height_reg <= '0;
            depth_mode_reg   <= DEPTH_NONE;
            dest_x_reg       <= '0;
            dest_y_reg       <= '0;
            dest_stride_reg  <= STRIDE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata[DIM_W-1:0];
                CFG_DEPTH_MODE:   depth_mode_reg   <= cfg_wdata[1:0];
                CFG_DEST_X:       dest_x_reg       <= cfg_wdata[DIM_W-1:0];
                CFG_DEST_Y:       dest_y_reg       <= cfg_wdata[DIM_W-1:0];
                CFG_DEST_STRIDE:  dest_stride_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Pipeline flow: the output register frees up or is empty.
    assign advance  = !out_vld_reg || m_tready;
    assign process  = in_vld_reg && advance;
    assign s_tready = !in_vld_reg || advance;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_tready) begin
            in_vld_next = s_tvalid;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    // Static decode of the current configuration.
    assign enabled = (depth_mode_reg != DEPTH_NONE) && (image_width_reg != '0)
                     && (image_height_reg != '0);
    assign top5    = in_byte_reg[BYTE_W-1:BYTE_W-5];

    always_comb begin
        case (depth_mode_reg)
            DEPTH_16: pixel_bytes = 3'd2;
            DEPTH_24: pixel_bytes = 3'd3;
            default:  pixel_bytes = 3'd4;
        endcase
    end

    // Destination address of the pixel being finished; rows are flipped.
    assign flipped    = (row_reg >= image_height_reg) ? '0
                        : image_height_reg - DIM_W'(1) - row_reg;
    assign dest_row   = {1'b0, dest_y_reg} + {1'b0, flipped};
    assign row_offset = dest_row * dest_stride_reg;
    assign column_end = ({1'b0, column_reg} + 11'd1) >= {1'b0, image_width_reg};
    assign row_end    = ({1'b0, row_reg} + 11'd1) >= {1'b0, image_height_reg};

    // Byte assembly, counters and row padding.
    always_comb begin
        byte_phase_next = byte_phase_reg;
        partial_next    = partial_reg;
        column_next     = column_reg;
        row_next        = row_reg;
        row_phase_next  = row_phase_reg;
        in_padding_next = in_padding_reg;
        emit            = 1'b0;
        out_last_next   = 1'b0;
        pixel_done      = 1'b0;

        if (process && enabled) begin
            row_phase_next = row_phase_reg + 2'd1;
            if (in_padding_reg) begin
                if (row_phase_next == 2'd0) begin
                    in_padding_next = 1'b0;
                end
            end else begin
                // Gather the pixel into blue 4:0, green 9:5, red 14:10.
                if (depth_mode_reg == DEPTH_16) begin
                    if (byte_phase_reg == 2'd0) begin
                        partial_next = {8'd0, in_byte_reg};
                    end else begin
                        partial_next = {in_byte_reg, partial_reg[7:0]};
                    end
                end else begin
                    case (byte_phase_reg)
                        2'd0:    partial_next = {11'd0, top5};
                        2'd1:    partial_next = {1'b0, partial_reg[14:10], top5,
                                                 partial_reg[4:0]};
                        2'd2:    partial_next = {1'b0, top5, partial_reg[9:0]};
                        default: partial_next = partial_reg;
                    endcase
                end

                pixel_done = ({1'b0, byte_phase_reg} + 3'd1) >= pixel_bytes;
                if (!pixel_done) begin
                    byte_phase_next = byte_phase_reg + 2'd1;
                end else begin
                    byte_phase_next = 2'd0;
                    emit            = 1'b1;
                    if (column_end) begin
                        column_next = '0;
                        if (row_end) begin
                            row_next      = '0;
                            out_last_next = 1'b1;
                        end else begin
                            row_next = row_reg + DIM_W'(1);
                        end
                        if (row_phase_next != 2'd0) begin
                            in_padding_next = 1'b1;
                        end
                    end else begin
                        column_next = column_reg + DIM_W'(1);
                    end
                end
            end
        end
    end

    // Result word: channels swapped into red 4:0, green 9:5, blue 14:10.
    assign out_pix_next  = PIX_OPAQUE | {1'b0, partial_next[4:0], partial_next[9:5],
                                         partial_next[14:10]};
    assign out_addr_next = row_offset[ADDR_W-1:0]
                           + {{(ADDR_W-DIM_W){1'b0}}, dest_x_reg}
                           + {{(ADDR_W-DIM_W){1'b0}}, column_reg};

    always_comb begin
        out_vld_next = out_vld_reg;
        if (advance) begin
            out_vld_next = emit;
        end
    end

    // State and output registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_phase_reg <= 2'd0;
            partial_reg    <= '0;
            column_reg     <= '0;
            row_reg        <= '0;
            row_phase_reg  <= 2'd0;
            in_padding_reg <= 1'b0;
            out_vld_reg    <= 1'b0;
        end else begin
            byte_phase_reg <= byte_phase_next;
            partial_reg    <= partial_next;
            column_reg     <= column_next;
            row_reg        <= row_next;
            row_phase_reg  <= row_phase_next;
            in_padding_reg <= in_padding_next;
            out_vld_reg    <= out_vld_next;
        end
        if (emit) begin
            out_addr_reg <= out_addr_next;
            out_pix_reg  <= out_pix_next;
            out_last_reg <= out_last_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_pix_reg, out_addr_reg};
    assign m_tlast  = out_last_reg;

    // Padding only starts on a pixel boundary.
    a_padding_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        in_padding_reg |-> (byte_phase_reg == 2'd0))
        else $error("row padding entered in the middle of a pixel");

    // While the final pixel waits, the counters have already wrapped.
    a_last_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (column_reg == '0 && row_reg == '0))
        else $error("final pixel issued without wrapping the counters");

    // A new write only follows a byte held in the input register.
    a_write_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !$past(m_tvalid)) |-> $past(in_vld_reg))
        else $error("frame-buffer write without a source byte");

endmodule : bmp_pixel_to_rgb555_writer_unit

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking testbench for the BMP pixel to RGB555 frame-buffer writer.
`default_nettype none

module tb;
    import b2r_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One frame-buffer write as seen on the result channel.
    typedef struct {
        logic [ADDR_W-1:0] address;
        logic [PIX_W-1:0]  color;
        logic              last;
    } fb_write_t;

    // Tracks the converter state and the frame-buffer writes still owed by the block.
    class rgb555_scoreboard;
        bit [DIM_W-1:0]    width, height, dest_x, dest_y;
        depth_t            depth;
        bit [STRIDE_W-1:0] stride;
        bit [1:0]          pixel_phase;
        bit [15:0]         gathered;
        bit [DIM_W-1:0]    col, row;
        bit [1:0]          row_phase;
        bit                padding;
        fb_write_t         expected_writes[$];
        int                errors;
        int                active_bytes;
        int                writes_seen;

        function new();
            width = '0;
            height = '0;
            depth = DEPTH_NONE;
            dest_x = '0;
            dest_y = '0;
            stride = STRIDE_RESET;
            pixel_phase = '0;
            gathered = '0;
            col = '0;
            row = '0;
            row_phase = '0;
            padding = 1'b0;
            errors = 0;
            active_bytes = 0;
            writes_seen = 0;
        endfunction

        function void set_reg(cfg_index_t idx, bit [STRIDE_W-1:0] value);
            case (idx)
                CFG_IMAGE_WIDTH:  width = value[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: height = value[DIM_W-1:0];
                CFG_DEPTH_MODE:   depth = depth_t'(value[1:0]);
                CFG_DEST_X:       dest_x = value[DIM_W-1:0];
                CFG_DEST_Y:       dest_y = value[DIM_W-1:0];
                CFG_DEST_STRIDE:  stride = value;
                default: ;
            endcase
        endfunction

        // Advances the converter by one accepted byte and records any write it completes.
        function void take_byte(bit [7:0] b);
            int unsigned pix_bytes, phase, flipped, addr;
            fb_write_t   wr;
            if (depth == DEPTH_NONE || width == 0 || height == 0) return;
            active_bytes++;
            row_phase = row_phase + 2'd1;

            // Row padding bytes are swallowed until the row reaches a 4-byte boundary.
            if (padding) begin
                if (row_phase == 0) padding = 1'b0;
                return;
            end

            pix_bytes = (depth == DEPTH_16) ? 2 : (depth == DEPTH_24) ? 3 : 4;
            phase = pixel_phase;
            if (depth == DEPTH_16) begin
                if (phase == 0) gathered = {8'h00, b};
                else gathered = {b, gathered[7:0]};
            end else begin
                case (phase)
                    0: gathered = {11'd0, b[7:3]};
                    1: gathered = {1'b0, gathered[14:10], b[7:3], gathered[4:0]};
                    2: gathered = {1'b0, b[7:3], gathered[9:0]};
                    default: ;
                endcase
            end
            if (phase + 1 < pix_bytes) begin
                pixel_phase = 2'(phase + 1);
                return;
            end
            pixel_phase = '0;

            // Swap red and blue into the frame-buffer layout and place the pixel.
            wr.color = {1'b1, gathered[4:0], gathered[9:5], gathered[14:10]};
            flipped = (row >= height) ? 0 : int'(height) - 1 - int'(row);
            addr = dest_x + col + (dest_y + flipped) * stride;
            wr.address = addr[ADDR_W-1:0];
            wr.last = 1'b0;
            if (int'(col) + 1 >= int'(width)) begin
                col = '0;
                if (int'(row) + 1 >= int'(height)) begin
                    row = '0;
                    wr.last = 1'b1;
                end else begin
                    row = row + 1'b1;
                end
                if (row_phase != 0) padding = 1'b1;
            end else begin
                col = col + 1'b1;
            end
            expected_writes.push_back(wr);
        endfunction

        // Compares one accepted write transaction with the oldest outstanding write.
        function void check_write(logic [ADDR_W+PIX_W-1:0] data, logic last);
            fb_write_t wr;
            writes_seen++;
            if (expected_writes.size() == 0) begin
                $error("unexpected write: write_address %0h pixel_value %0h last_pixel %0b",
                       data[ADDR_W-1:0], data[ADDR_W+PIX_W-1:ADDR_W], last);
                errors++;
                return;
            end
            wr = expected_writes.pop_front();
            if (data[ADDR_W-1:0] !== wr.address) begin
                $error("write_address: expected %0h, actual %0h", wr.address, data[ADDR_W-1:0]);
                errors++;
            end
            if (data[ADDR_W+PIX_W-1:ADDR_W] !== wr.color) begin
                $error("pixel_value: expected %0h, actual %0h",
                       wr.color, data[ADDR_W+PIX_W-1:ADDR_W]);
                errors++;
            end
            if (last !== wr.last) begin
                $error("last_pixel: expected %0b, actual %0b", wr.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [STRIDE_W-1:0]    cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [ADDR_W+PIX_W-1:0] m_tdata;
    logic                   m_tlast;

    rgb555_scoreboard sb = new();
    bit [7:0]         stream_bytes[$];
    bit               long_hold_done = 1'b0;

    bmp_pixel_to_rgb555_writer_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // Result monitor: every accepted write transaction goes to the scoreboard.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_write(m_tdata, m_tlast);
    end

    // Receiver: changes its stall pattern now and then, and once holds off for a long stretch.
    initial begin
        int mode, mode_left, hold_left;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!long_hold_done && sb.writes_seen >= 60 && s_tvalid) begin
                long_hold_done = 1'b1;
                hold_left = 150;
                m_tready <= 1'b0;
            end else begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) == 1);
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ~m_tready;
                endcase
            end
        end
    end

    // Offers one byte and waits for its transaction.
    task automatic send_byte(input bit [7:0] b);
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge aclk); while (!s_tready);
        sb.take_byte(b);
    endtask

    // Sends the queued bytes in bursts with random gaps between them.
    task automatic send_stream(input bit no_gaps);
        int burst, gap;
        burst = $urandom_range(1, 20);
        while (stream_bytes.size() != 0) begin
            send_byte(stream_bytes.pop_front());
            burst--;
            if (burst == 0) begin
                burst = $urandom_range(1, 20);
                gap = no_gaps ? 0 : $urandom_range(0, 6);
                if (gap != 0 && stream_bytes.size() != 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
        s_tvalid <= 1'b0;
    endtask

    // Waits until every write has arrived and trailing padding bytes have left the pipeline.
    task automatic wait_idle();
        while (sb.expected_writes.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input bit [STRIDE_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.set_reg(idx, value);
    endtask

    task automatic apply_config(input bit [STRIDE_W-1:0] w, input bit [STRIDE_W-1:0] h,
                                input depth_t d, input bit [STRIDE_W-1:0] x,
                                input bit [STRIDE_W-1:0] y, input bit [STRIDE_W-1:0] st);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_DEPTH_MODE, {9'd0, d});
        write_reg(CFG_DEST_X, x);
        write_reg(CFG_DEST_Y, y);
        write_reg(CFG_DEST_STRIDE, st);
        cfg_wr_en <= 1'b0;
    endtask

    // Stimulus: directed corner cases, then random configurations and images.
    initial begin
        int     w, h, x, y, st, pix_bytes, row_bytes, total, goal, r;
        depth_t d;
        bit     well_formed;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Unsupported depth straight after reset: the byte is dropped.
        stream_bytes = '{8'hFF};
        send_stream(1'b1);

        // Two-row 24-bit image with one padding byte per row, placed at the far corner.
        wait_idle();
        apply_config(1, 2, DEPTH_24, 1023, 1023, 2047);
        stream_bytes = '{8'hFF, 8'h00, 8'hFF, 8'h55, 8'h00, 8'hFF, 8'h80, 8'hAA};
        send_stream(1'b0);

        // 16-bit pixels with zero stride; the stream runs on into a second image.
        wait_idle();
        apply_config(2, 1, DEPTH_16, 0, 0, 0);
        stream_bytes = '{8'hFF, 8'h7F, 8'h00, 8'h80, 8'h1F, 8'h00};
        send_stream(1'b1);

        // Three bytes of a 32-bit pixel, then the depth drops to 16 bits mid-pixel.
        wait_idle();
        apply_config(1, 1, DEPTH_32, 5, 7, 1024);
        stream_bytes = '{8'h12, 8'h34, 8'h56};
        send_stream(1'b1);
        wait_idle();
        apply_config(1, 1, DEPTH_16, 5, 7, 1024);
        stream_bytes = '{8'hC3};
        send_stream(1'b1);

        // Width shrinks in the middle of a row.
        wait_idle();
        apply_config(3, 2, DEPTH_24, 9, 3, 17);
        stream_bytes = '{8'h08, 8'h10, 8'hF8};
        send_stream(1'b1);
        wait_idle();
        apply_config(1, 2, DEPTH_24, 9, 3, 17);
        stream_bytes = '{8'hE7, 8'h18, 8'h3C};
        send_stream(1'b1);

        // Empty image, then the largest image size.
        wait_idle();
        apply_config(0, 4, DEPTH_24, 0, 0, 1);
        stream_bytes = '{8'h00};
        send_stream(1'b1);
        wait_idle();
        apply_config(1023, 1023, DEPTH_16, 512, 256, 64);
        stream_bytes = '{8'hA5, 8'h5A};
        send_stream(1'b1);

        // Random phases: mostly whole images of small size, some noise and odd settings.
        goal = sb.active_bytes + 500;
        while (sb.active_bytes < goal) begin
            wait_idle();
            r = $urandom_range(0, 99);
            w = (r < 5) ? 0 : (r < 10) ? $urandom_range(0, 2047) : $urandom_range(1, 6);
            r = $urandom_range(0, 99);
            h = (r < 5) ? 0 : (r < 10) ? $urandom_range(0, 2047) : $urandom_range(1, 4);
            d = ($urandom_range(0, 9) == 0) ? DEPTH_NONE : depth_t'($urandom_range(1, 3));
            x = $urandom_range(0, 2047);
            y = $urandom_range(0, 2047);
            case ($urandom_range(0, 9))
                0: st = 0;
                1: st = 2047;
                2: st = $urandom_range(0, 2047);
                default: st = $urandom_range(1, 1024);
            endcase
            apply_config(w, h, d, x, y, st);

            well_formed = (d != DEPTH_NONE) && (w[9:0] >= 1) && (w[9:0] <= 6)
                          && (h[9:0] >= 1) && (h[9:0] <= 4) && ($urandom_range(0, 99) < 80);
            if (well_formed) begin
                pix_bytes = (d == DEPTH_16) ? 2 : (d == DEPTH_24) ? 3 : 4;
                row_bytes = (w[9:0] * pix_bytes + 3) / 4 * 4;
                total = row_bytes * h[9:0] * $urandom_range(1, 3);
                if (total > 150) total = row_bytes * h[9:0];
            end else begin
                total = $urandom_range(1, 40);
            end
            repeat (total) stream_bytes.push_back(8'($urandom_range(0, 255)));
            send_stream($urandom_range(0, 3) == 0);
        end

        wait_idle();
        if (sb.errors == 0 && sb.expected_writes.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
